@@ design/mldf_pkg.sv @@
`timescale 1ns / 1ps

package mldf_pkg;

  // data path sizes
  localparam int DELAY_W   = 48;
  localparam int MAX_WIN   = 256;
  localparam int ADDR_W    = 8;
  localparam int CNT_W     = 9;
  localparam int BIT_IDX_W = 6;
  localparam int THR_W     = 32;
  localparam int CFG_W     = 32;
  localparam int STEP_CAP  = 640;
  localparam int STEP_W    = 10;
  localparam int FACTOR_W  = 17;
  localparam int REM_W     = 42;

  localparam logic [CNT_W-1:0] WIN_RESET = 9'd16;
  localparam logic [THR_W-1:0] THR_RESET = 32'd50000;

  // register indexes
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_THRESHOLD     = 1'b1;

  // input commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MEDIAN, ST_DIFF, ST_CAP, ST_DIV, ST_ROM, ST_MUL_HI, ST_MUL_LO
  } top_state_t;

  typedef enum logic [1:0] {
    SEL_IDLE, SEL_SCAN, SEL_MEAN
  } sel_state_t;

  // median request toward the window unit
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] count;
  } sel_req_t;

  // log weight table in Q1.16
  typedef logic [FACTOR_W-1:0] factor_rom_t [0:STEP_CAP];

  localparam real LnEleven = $ln(11.0);

  function automatic factor_rom_t build_factor_rom();
    factor_rom_t rom;
    real         v;
    int          r;
    for (int k = 0; k <= STEP_CAP; k++) begin
      v = 65536.0 * $ln(1.0 + real'(k) / 64.0) / LnEleven;
      r = $rtoi(v + 0.5);
      if (r > 65536) r = 65536;
      rom[k] = FACTOR_W'(r);
    end
    return rom;
  endfunction

  localparam factor_rom_t FACTOR_ROM = build_factor_rom();

endpackage

@@ design/mldf_window.sv @@
`timescale 1ns / 1ps

module mldf_window (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [mldf_pkg::ADDR_W-1:0]    wr_addr,
  input  logic [mldf_pkg::DELAY_W-1:0]   wr_data,
  input  mldf_pkg::sel_req_t             req,
  output logic                           done,
  output logic [mldf_pkg::DELAY_W-1:0]   median
);
  import mldf_pkg::*;

  localparam logic [DELAY_W-1:0] SIGN_MASK = {1'b1, {(DELAY_W-1){1'b0}}};

  // sample ring storage
  logic [DELAY_W-1:0] mem [0:MAX_WIN-1];
  logic [DELAY_W-1:0] rd_data_r;

  sel_state_t           state_r, state_nxt;
  logic [BIT_IDX_W-1:0] b_r;
  logic [CNT_W-1:0]     a_r, n_r, cnt_lo_r, cnt_hi_r;
  logic [ADDR_W-1:0]    k_lo_r, k_hi_r;
  logic [DELAY_W-1:0]   p_lo_r, p_hi_r, m_r, med_r;
  logic                 rv_r, done_r;

  logic                 rd_en, pass_end;
  logic [DELAY_W-1:0]   bitb, sel, x_u;
  logic                 hit_lo, hit_hi;
  logic [CNT_W-1:0]     tot_lo, tot_hi;
  logic [DELAY_W:0]     sum;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[a_r[ADDR_W-1:0]];
  end

  // compare one word against both prefixes
  always_comb begin
    bitb   = DELAY_W'(1) << b_r;
    sel    = m_r | bitb;
    x_u    = rd_data_r ^ SIGN_MASK;
    hit_lo = rv_r && (((x_u ^ p_lo_r) & sel) == '0);
    hit_hi = rv_r && (((x_u ^ p_hi_r) & sel) == '0);
    tot_lo = cnt_lo_r + CNT_W'(hit_lo);
    tot_hi = cnt_hi_r + CNT_W'(hit_hi);
    sum    = {p_lo_r[DELAY_W-1] ^ 1'b1, p_lo_r ^ SIGN_MASK}
           + {p_hi_r[DELAY_W-1] ^ 1'b1, p_hi_r ^ SIGN_MASK};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEL_IDLE: if (req.start) state_nxt = SEL_SCAN;
      SEL_SCAN: if (pass_end && b_r == '0) state_nxt = SEL_MEAN;
      SEL_MEAN: state_nxt = SEL_IDLE;
      default:  state_nxt = SEL_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    rd_en    = 1'b0;
    pass_end = 1'b0;
    case (state_r)
      SEL_SCAN: begin
        rd_en    = (a_r < n_r);
        pass_end = (a_r == n_r);
      end
      default: begin
        rd_en    = 1'b0;
        pass_end = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEL_IDLE;
      rv_r    <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= rd_en;
      done_r  <= (state_r == SEL_MEAN);
    end
  end

  // radix select of the two middle ranks, one bit per pass
  always_ff @(posedge clk) begin
    case (state_r)
      SEL_IDLE: begin
        if (req.start) begin
          n_r      <= req.count;
          k_hi_r   <= ADDR_W'(req.count >> 1);
          k_lo_r   <= ADDR_W'((req.count - CNT_W'(1)) >> 1);
          b_r      <= BIT_IDX_W'(DELAY_W - 1);
          a_r      <= '0;
          cnt_lo_r <= '0;
          cnt_hi_r <= '0;
          p_lo_r   <= '0;
          p_hi_r   <= '0;
          m_r      <= '0;
        end
      end
      SEL_SCAN: begin
        if (pass_end) begin
          if ({1'b0, k_lo_r} >= tot_lo) begin
            p_lo_r <= p_lo_r | bitb;
            k_lo_r <= k_lo_r - tot_lo[ADDR_W-1:0];
          end
          if ({1'b0, k_hi_r} >= tot_hi) begin
            p_hi_r <= p_hi_r | bitb;
            k_hi_r <= k_hi_r - tot_hi[ADDR_W-1:0];
          end
          m_r      <= sel;
          a_r      <= '0;
          cnt_lo_r <= '0;
          cnt_hi_r <= '0;
          if (b_r != '0) b_r <= b_r - BIT_IDX_W'(1);
        end else begin
          a_r      <= a_r + CNT_W'(1);
          cnt_lo_r <= tot_lo;
          cnt_hi_r <= tot_hi;
        end
      end
      SEL_MEAN: med_r <= sum[DELAY_W:1];
      default: ;
    endcase
  end

  assign done   = done_r;
  assign median = med_r;

endmodule

@@ design/median_log_delay_filter.sv @@
`timescale 1ns / 1ps

// Median / log-weighted delay smoother.
// Input channel: in_valid, in_stall, in_command, in_sample_delay. A sample word
// (command 0) enters the ring window and yields one out_smoothed_delay word; a
// clear word (command 1) empties the window, zeroes the last output and yields
// no word. The block takes one word at a time: in_stall stays high from the
// accepted sample until its result has been loaded into the output register.
// The median walk over the window memory takes one read per cycle and resolves
// one result bit per pass. A clear word does not raise in_stall.
// Output channel: out_valid, out_stall, out_smoothed_delay. The output register
// holds a word under out_stall while the next input word is already taken.
// Configuration: cfg_wr_en, cfg_index, cfg_data, written while idle.
// Reset: rst_n low clears the window pointers, the last output and the channel
// valids, and loads a window length of 16 and a threshold of 50000; the window
// memory itself is not cleared.
module median_log_delay_filter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_command,
  input  logic signed [mldf_pkg::DELAY_W-1:0] in_sample_delay,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [mldf_pkg::DELAY_W-1:0] out_smoothed_delay,
  input  logic                               cfg_wr_en,
  input  logic                               cfg_index,
  input  logic [mldf_pkg::CFG_W-1:0]         cfg_data
);
  import mldf_pkg::*;

  top_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]    wl_r, fill_r, len, fill_nxt;
  logic [THR_W-1:0]    thr_r, thr_e;
  logic [ADDR_W-1:0]   wp_r, pos;
  logic [DELAY_W-1:0]  last_r, mag_r, prodhi_r, adj, out_r, median, res;
  logic                up_r, out_valid_r, med_done, in_accept, sample_acc, out_free;
  logic [REM_W-1:0]    rem_r, div_d;
  logic [STEP_W-1:0]   q_r;
  logic [3:0]          j_r;
  logic [FACTOR_W-1:0] f_r;
  logic [35:0]         thr10;
  logic [31:0]         prodlo;
  sel_req_t            req;

  // effective settings
  always_comb begin
    if (wl_r == '0) len = CNT_W'(1);
    else if (wl_r > CNT_W'(MAX_WIN)) len = CNT_W'(MAX_WIN);
    else len = wl_r;
    thr_e    = (thr_r == '0) ? THR_W'(1) : thr_r;
    thr10    = ({4'b0, thr_e} << 3) + ({4'b0, thr_e} << 1);
    pos      = ({1'b0, wp_r} >= len) ? '0 : wp_r;
    fill_nxt = (fill_r < len) ? fill_r + CNT_W'(1) : len;
    div_d    = REM_W'({10'b0, thr_e} << j_r);
    prodlo   = mag_r[15:0] * f_r[15:0];
    adj      = f_r[16] ? mag_r : prodhi_r + {32'b0, prodlo[31:16]};
    res      = up_r ? last_r + adj : last_r - adj;
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign sample_acc = in_accept && (in_command == CMD_SAMPLE);
  assign out_free   = !out_valid_r || !out_stall;

  assign req.start = sample_acc;
  assign req.count = fill_nxt;

  mldf_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (sample_acc),
    .wr_addr (pos),
    .wr_data (in_sample_delay),
    .req     (req),
    .done    (med_done),
    .median  (median)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (sample_acc) state_nxt = ST_MEDIAN;
      ST_MEDIAN: if (med_done) state_nxt = ST_DIFF;
      ST_DIFF:   state_nxt = ST_CAP;
      ST_CAP:    state_nxt = (mag_r >= {12'b0, thr10}) ? ST_ROM : ST_DIV;
      ST_DIV:    if (j_r == '0) state_nxt = ST_ROM;
      ST_ROM:    state_nxt = ST_MUL_HI;
      ST_MUL_HI: state_nxt = ST_MUL_LO;
      ST_MUL_LO: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wl_r        <= WIN_RESET;
      thr_r       <= THR_RESET;
      wp_r        <= '0;
      fill_r      <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_WINDOW_LENGTH: wl_r  <= cfg_data[CNT_W-1:0];
          REG_THRESHOLD:     thr_r <= cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (in_accept && in_command == CMD_CLEAR) begin
        wp_r   <= '0;
        fill_r <= '0;
        last_r <= '0;
      end else if (sample_acc) begin
        wp_r   <= ({1'b0, pos} + CNT_W'(1) >= len) ? '0 : pos + ADDR_W'(1);
        fill_r <= fill_nxt;
      end else if (state_r == ST_MUL_LO && out_free) begin
        last_r <= res;
      end
      if (state_r == ST_MUL_LO && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // step index division and weighting
  always_ff @(posedge clk) begin
    case (state_r)
      ST_DIFF: begin
        up_r  <= ($signed(median) >= $signed(last_r));
        mag_r <= ($signed(median) >= $signed(last_r)) ? median - last_r : last_r - median;
      end
      ST_CAP: begin
        rem_r <= {mag_r[35:0], 6'b0};
        q_r   <= (mag_r >= {12'b0, thr10}) ? STEP_W'(STEP_CAP) : '0;
        j_r   <= 4'(STEP_W - 1);
      end
      ST_DIV: begin
        if (rem_r >= div_d) begin
          rem_r    <= rem_r - div_d;
          q_r[j_r] <= 1'b1;
        end
        if (j_r != '0) j_r <= j_r - 4'd1;
      end
      ST_ROM:    f_r <= FACTOR_ROM[q_r];
      ST_MUL_HI: prodhi_r <= mag_r[47:16] * f_r[15:0];
      default: ;
    endcase
    if (state_r == ST_MUL_LO && out_free) out_r <= res;
  end

  assign out_valid          = out_valid_r;
  assign out_smoothed_delay = out_r;

`ifndef ASSERT_OFF
  // a new word appears only on completion of the weighting step
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_MUL_LO))
    else $error("output word without a finished sample");

  // a clear word empties the window and the last output
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_command == CMD_CLEAR) |=> (fill_r == '0 && last_r == '0))
    else $error("clear word left filter state");

  // an accepted sample always leaves a non-empty window within the maximum length
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    sample_acc |=> (fill_r != '0 && fill_r <= CNT_W'(MAX_WIN)))
    else $error("fill count out of range");
`endif

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import mldf_pkg::*;

  localparam int     IDLE_LIMIT = 60000;
  localparam int     RANDOM_ITEMS = 575;
  localparam longint DMAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint DMIN = -64'sh0000_8000_0000_0000;

  typedef enum int {ROW_SAMPLE, ROW_CLEAR, ROW_SET_WIN, ROW_SET_THR} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [47:0]      value;
    bit               fixed;
    logic [47:0]      fixed_out;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_command;
  logic signed [DELAY_W-1:0] in_sample_delay;
  logic out_valid;
  logic out_stall;
  logic signed [DELAY_W-1:0] out_smoothed_delay;
  logic cfg_wr_en;
  logic cfg_index;
  logic [CFG_W-1:0] cfg_data;

  median_log_delay_filter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_sample_delay(in_sample_delay),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_smoothed_delay(out_smoothed_delay),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // smoother state mirror
  longint      win_mem [0:MAX_WIN-1];
  int          wr_pos;
  int          fill;
  longint      last_out;
  int          win_len_reg;
  longint      thr_reg;
  int          log_weight [0:STEP_CAP];
  logic [47:0] filtered_q [$];
  int          fail_cnt;
  bit          quiet;
  int          idle_cycles;
  int          out_burst;
  stim_row_t   rows [0:22];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int eff_len(int v);
    if (v == 0) return 1;
    if (v > MAX_WIN) return MAX_WIN;
    return v;
  endfunction

  // median of the filled window, log-weighted step toward it
  function automatic logic [47:0] smooth_delay(logic signed [47:0] smp);
    longint          srt [0:MAX_WIN-1];
    longint          v, med, d;
    longint unsigned mag, t, k, f, adj;
    int              len, p, j;
    bit              up;
    len = eff_len(win_len_reg);
    p = (wr_pos >= len) ? 0 : wr_pos;
    win_mem[p] = longint'(smp);
    wr_pos = (p + 1 >= len) ? 0 : p + 1;
    fill = (fill < len) ? fill + 1 : len;
    for (int i = 0; i < fill; i++) begin
      v = win_mem[i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    if (fill % 2 == 1) med = srt[fill/2];
    else med = (srt[fill/2-1] + srt[fill/2]) >>> 1;
    d = med - last_out;
    up = (med >= last_out);
    mag = up ? d : -d;
    t = (thr_reg == 0) ? 1 : thr_reg;
    if (mag >= t * 10) k = STEP_CAP;
    else k = (mag * 64) / t;
    if (k > STEP_CAP) k = STEP_CAP;
    f = log_weight[k];
    if (f >= 65536) adj = mag;
    else adj = (mag >> 16) * f + (((mag & 64'hFFFF) * f) >> 16);
    v = up ? last_out + longint'(adj) : last_out - longint'(adj);
    last_out = longint'($signed(v[47:0]));
    return v[47:0];
  endfunction

  // one input word through the handshake, prediction at acceptance
  task automatic send_word(logic cmd, logic [47:0] val, bit fixed, logic [47:0] fixed_out);
    logic [47:0] pred;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_command <= $urandom_range(0, 1);
      in_sample_delay <= {$urandom, $urandom};
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_sample_delay <= val;
    do @(posedge clk); while (in_stall);
    if (cmd == CMD_CLEAR) begin
      wr_pos = 0;
      fill = 0;
      last_out = 0;
    end else begin
      pred = smooth_delay(val);
      filtered_q.push_back(fixed ? fixed_out : pred);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_data <= {$urandom};
  endtask

  // a grown window gets a clear so no unwritten entry is ever read
  task automatic set_window(int v);
    bit grows;
    drain();
    grows = eff_len(v & 9'h1FF) > eff_len(win_len_reg);
    write_reg(REG_WINDOW_LENGTH, v);
    win_len_reg = v & 9'h1FF;
    if (grows) send_word(CMD_CLEAR, 48'd0, 1'b0, 48'd0);
  endtask

  task automatic set_threshold(longint v);
    drain();
    write_reg(REG_THRESHOLD, v[31:0]);
    thr_reg = v & 64'hFFFF_FFFF;
  endtask

  // receiver stalls in bursts
  always @(negedge clk) begin
    if (quiet || !rst_n) begin
      out_stall <= 1'b0;
    end else if (out_burst > 0) begin
      out_burst <= out_burst - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_burst <= $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result check
  always @(posedge clk) begin
    logic [47:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (filtered_q.size() == 0) begin
        $error("unexpected word: smoothed_delay %0d", out_smoothed_delay);
        fail_cnt++;
      end else begin
        want = filtered_q.pop_front();
        if (out_smoothed_delay !== want) begin
          $error("smoothed_delay: expected %0d, got %0d", $signed(want), out_smoothed_delay);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[median_log_delay_filter] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          done, n, pick, mode;
    longint      base, spread, s;
    logic [47:0] val;
    for (int k = 0; k <= STEP_CAP; k++) begin
      log_weight[k] = int'($floor(65536.0 * $ln(1.0 + k / 64.0) / $ln(11.0) + 0.5));
      if (log_weight[k] > 65536) log_weight[k] = 65536;
    end
    for (int i = 0; i < MAX_WIN; i++) win_mem[i] = 0;
    wr_pos = 0; fill = 0; last_out = 0;
    win_len_reg = WIN_RESET; thr_reg = THR_RESET;
    fail_cnt = 0; quiet = 0; idle_cycles = 0; out_burst = 0;
    rst_n = 1'b0; in_valid = 1'b0; in_command = CMD_SAMPLE; in_sample_delay = '0;
    out_stall = 1'b0; cfg_wr_en = 1'b0; cfg_index = REG_WINDOW_LENGTH; cfg_data = '0;

    rows = '{
      '{ROW_CLEAR,  48'd0,               0, 48'd0},
      '{ROW_SAMPLE, 48'd0,               1, 48'd0},
      '{ROW_SAMPLE, 48'd5,               1, 48'd0},
      '{ROW_SAMPLE, 48'h7FFF_FFFF_FFFF,  0, 48'd0},
      '{ROW_SAMPLE, 48'h8000_0000_0000,  0, 48'd0},
      '{ROW_SAMPLE, 48'hFFFF_FFFF_FFFF,  0, 48'd0},
      '{ROW_SET_THR, 48'd0,              0, 48'd0},
      '{ROW_SET_WIN, 48'd0,              0, 48'd0},
      '{ROW_SAMPLE, 48'h7FFF_FFFF_FFFF,  1, 48'h7FFF_FFFF_FFFF},
      '{ROW_SAMPLE, 48'h8000_0000_0000,  1, 48'h8000_0000_0000},
      '{ROW_SET_WIN, 48'd511,            0, 48'd0},
      '{ROW_SAMPLE, 48'd12345,           0, 48'd0},
      '{ROW_SAMPLE, -48'sd777,           0, 48'd0},
      '{ROW_SAMPLE, 48'd40000,           0, 48'd0},
      '{ROW_SET_THR, 48'hFFFF_FFFF,      0, 48'd0},
      '{ROW_SAMPLE, 48'd1,               0, 48'd0},
      '{ROW_SET_WIN, 48'd2,              0, 48'd0},
      '{ROW_SAMPLE, -48'sd3,             0, 48'd0},
      '{ROW_SAMPLE, 48'd9,               0, 48'd0},
      '{ROW_SET_THR, 48'd1000,           0, 48'd0},
      '{ROW_SAMPLE, 48'd3000,            0, 48'd0},
      '{ROW_SAMPLE, 48'd7000,            0, 48'd0},
      '{ROW_SAMPLE, -48'sd2500,          0, 48'd0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows
    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_SAMPLE:  send_word(CMD_SAMPLE, rows[i].value, rows[i].fixed, rows[i].fixed_out);
        ROW_CLEAR:   send_word(CMD_CLEAR, rows[i].value, 1'b0, 48'd0);
        ROW_SET_WIN: set_window(int'(rows[i].value));
        default:     set_threshold(longint'(rows[i].value));
      endcase
    end

    // random phases, mostly short windows
    done = 0;
    while (done < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        set_window($urandom_range(0, 1) ? 511 : 300);
        n = 4;
      end else if (pick == 1) begin
        set_window(0);
        n = $urandom_range(5, 15);
      end else begin
        set_window($urandom_range(1, 10));
        n = $urandom_range(10, 35);
      end
      case ($urandom_range(0, 4))
        0: set_threshold(0);
        1: set_threshold(1);
        2: set_threshold($urandom_range(1, 1000));
        3: set_threshold({$urandom});
        default: set_threshold($urandom_range(20000, 80000));
      endcase
      base = longint'($signed({$urandom, $urandom} & 48'hFFFF_FFFF_FFFF)) >>> $urandom_range(0, 40);
      spread = (thr_reg == 0 ? 1 : thr_reg) * $urandom_range(1, 12);
      for (int i = 0; i < n && done < RANDOM_ITEMS; i++) begin
        if (done > RANDOM_ITEMS - 60) quiet = 1;
        mode = $urandom_range(0, 19);
        if (mode == 0) begin
          send_word(CMD_CLEAR, {$urandom, $urandom}, 1'b0, 48'd0);
        end else begin
          if (mode <= 13) begin
            s = base + longint'($urandom_range(0, 2000)) * spread / 1000 - spread;
            if (s > DMAX) s = DMAX;
            if (s < DMIN) s = DMIN;
            val = s[47:0];
          end else if (mode <= 17) begin
            val = {$urandom, $urandom};
          end else begin
            val = $urandom_range(0, 1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
          end
          send_word(CMD_SAMPLE, val, 1'b0, 48'd0);
        end
        done++;
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (fail_cnt == 0 && filtered_q.size() == 0) begin
      $display("[median_log_delay_filter] OK");
    end else begin
      $display("[median_log_delay_filter] ERROR");
    end
    $finish;
  end

endmodule
